// ----- rtl/core/uncertainty_propagation_alu_macros.svh -----
// Assertion macros for the uncertainty propagation ALU.
// Used by the top level; no other dependencies.
`ifndef UNCERTAINTY_PROPAGATION_ALU_MACROS_SVH
`define UNCERTAINTY_PROPAGATION_ALU_MACROS_SVH

// same-cycle implication
`define UPA_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define UPA_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/core/upa_pkg.sv -----
// Package for the uncertainty propagation ALU: operation codes and defaults.
// No dependencies.
`default_nettype none
package upa_pkg;

    localparam int UPA_WORD_BITS = 32;
    localparam int UPA_FRAC_BITS = 16;

    typedef enum logic [1:0] {
        OP_ADD = 2'd0,
        OP_SUB = 2'd1,
        OP_MUL = 2'd2,
        OP_DIV = 2'd3
    } t_op;

endpackage
`default_nettype wire

// ----- rtl/core/uncertainty_propagation_alu.sv -----
// Uncertainty propagation ALU: first-order error propagation, fully pipelined.
// Depends on upa_pkg and uncertainty_propagation_alu_macros.svh.
// Stages: four front stages, 2*WORD_BITS square-root stages,
//   2*WORD_BITS+FRAC_BITS divider stages and an output register.
// Throughput: one transfer per cycle; the whole pipeline holds while the output stalls.
// Reset: synchronous active low, clears all stage valid bits.
`default_nettype none
`include "uncertainty_propagation_alu_macros.svh"
module uncertainty_propagation_alu #(
    parameter int WORD_BITS = upa_pkg::UPA_WORD_BITS,
    parameter int FRAC_BITS = upa_pkg::UPA_FRAC_BITS
) (
    input  wire logic                                        i_clk,
    input  wire logic                                        i_rst_n,
    input  wire logic                                        i_s_axis_tvalid,
    output logic                                             o_s_axis_tready,
    // a_value, a_sigma, b_value, b_sigma
    input  wire logic [((4*WORD_BITS-2+7)/8)*8-1:0]          i_s_axis_tdata,
    // operation
    input  wire logic [1:0]                                  i_s_axis_tuser,
    output logic                                             o_m_axis_tvalid,
    input  wire logic                                        i_m_axis_tready,
    // result_value, result_sigma
    output logic [((2*WORD_BITS-1+7)/8)*8-1:0]               o_m_axis_tdata,
    // divide_by_zero, overflow
    output logic [1:0]                                       o_m_axis_tuser
);
    import upa_pkg::*;

    localparam int W   = WORD_BITS;
    localparam int F   = FRAC_BITS;
    localparam int TW  = 2 * W;
    localparam int XW  = 4 * W;
    localparam int RW  = 2 * W;
    localparam int NQ  = 2 * W + F;
    localparam int ODW = ((2*W-1+7)/8)*8;

    typedef struct packed {
        logic              v;
        t_op               op;
        logic              na;
        logic              nb;
        logic [W-1:0]      ma;
        logic [W-1:0]      mb;
        logic [W-2:0]      sa;
        logic [W-2:0]      sb;
        logic [W:0]        sum;
    } t_s1;

    typedef struct packed {
        logic              v;
        t_op               op;
        logic              neg;
        logic              dz;
        logic [W:0]        sum;
        logic [W-1:0]      ma;
        logic [W-1:0]      mb;
        logic [TW-1:0]     pv;
        logic [TW-1:0]     t1;
        logic [TW-1:0]     t2;
        logic [TW-1:0]     sa2;
        logic [TW-1:0]     sb2;
        logic [TW-1:0]     mb2;
    } t_s2;

    typedef struct packed {
        logic              v;
        t_op               op;
        logic              neg;
        logic              dz;
        logic [W-1:0]      vres;
        logic              vovf;
        logic [W-1:0]      ma;
        logic [W-1:0]      mb;
        logic [TW-1:0]     mb2;
        logic [TW-1:0]     hh1;
        logic [TW-1:0]     hl1;
        logic [TW-1:0]     ll1;
        logic [TW-1:0]     hh2;
        logic [TW-1:0]     hl2;
        logic [TW-1:0]     ll2;
        logic [TW-1:0]     ss;
    } t_s3;

    typedef struct packed {
        logic              v;
        t_op               op;
        logic              neg;
        logic              dz;
        logic [W-1:0]      vres;
        logic              vovf;
        logic [W-1:0]      ma;
        logic [W-1:0]      mb;
        logic [TW-1:0]     mb2;
        logic [XW-1:0]     x;
        logic [RW+1:0]     rem;
        logic [RW-1:0]     root;
    } t_sq;

    typedef struct packed {
        logic              v;
        t_op               op;
        logic              neg;
        logic              dz;
        logic [W-1:0]      vres;
        logic              vovf;
        logic [W-2:0]      sres;
        logic              sovf;
        logic [W-1:0]      mb;
        logic [TW-1:0]     mb2;
        logic [NQ-1:0]     vq;
        logic [W-1:0]      vr;
        logic [NQ-1:0]     sq;
        logic [TW-1:0]     sr;
    } t_dv;

    // {overflow, value}
    function automatic logic [W:0] f_sat(input logic neg, input logic [NQ-1:0] mag);
        logic [NQ-1:0] lim;
        logic [NQ-1:0] m;
        logic [W-1:0]  val;
        logic          o;
        lim = (NQ'(1) << (W-1)) - NQ'(!neg);
        o   = mag > lim;
        m   = o ? lim : mag;
        val = m[W-1:0];
        if (neg) begin
            val = -val;
        end
        return {o, val};
    endfunction

    // {overflow, sigma}
    function automatic logic [W-1:0] f_sig(input logic [NQ-1:0] s);
        logic [NQ-1:0] smax;
        logic          o;
        smax = (NQ'(1) << (W-1)) - NQ'(1);
        o    = s > smax;
        return {o, o ? smax[W-2:0] : s[W-2:0]};
    endfunction

    function automatic t_sq f_sq_step(input t_sq s);
        t_sq            r;
        logic [RW+3:0]  t;
        logic [RW+3:0]  trial;
        r     = s;
        t     = {s.rem, s.x[XW-1 -: 2]};
        trial = (RW+4)'({s.root, 2'b01});
        if (t >= trial) begin
            r.rem  = (RW+2)'(t - trial);
            r.root = {s.root[RW-2:0], 1'b1};
        end else begin
            r.rem  = (RW+2)'(t);
            r.root = {s.root[RW-2:0], 1'b0};
        end
        r.x = {s.x[XW-3:0], 2'b00};
        return r;
    endfunction

    function automatic t_dv f_dv_step(input t_dv s);
        t_dv            r;
        logic [W:0]     tv;
        logic [TW:0]    ts;
        logic           gv;
        logic           gs;
        r  = s;
        tv = {s.vr, s.vq[NQ-1]};
        ts = {s.sr, s.sq[NQ-1]};
        gv = tv >= (W+1)'(s.mb);
        gs = ts >= (TW+1)'(s.mb2);
        r.vr = gv ? W'(tv - (W+1)'(s.mb)) : W'(tv);
        r.sr = gs ? TW'(ts - (TW+1)'(s.mb2)) : TW'(ts);
        r.vq = {s.vq[NQ-2:0], gv};
        r.sq = {s.sq[NQ-2:0], gs};
        return r;
    endfunction

    logic          adv;
    t_s1           r_s1, n_s1;
    t_s2           r_s2, n_s2;
    t_s3           r_s3, n_s3;
    t_sq           r_s4, n_s4;
    t_sq           r_sq [RW];
    t_sq           n_sq [RW];
    t_dv           dv_entry;
    t_dv           r_dv [NQ];
    t_dv           n_dv [NQ];
    logic          r_out_v;
    logic [W-1:0]  r_out_val, n_out_val;
    logic [W-2:0]  r_out_sig, n_out_sig;
    logic          r_out_dz, n_out_dz;
    logic          r_out_ovf, n_out_ovf;

    assign adv             = !r_out_v || i_m_axis_tready;
    assign o_s_axis_tready = adv;

    // stage 1: unpack, magnitudes, add/sub sum
    always_comb begin
        logic [W-1:0] a;
        logic [W-1:0] b;
        a           = i_s_axis_tdata[W-1:0];
        b           = i_s_axis_tdata[3*W-2:2*W-1];
        n_s1.v      = i_s_axis_tvalid;
        n_s1.op     = t_op'(i_s_axis_tuser);
        n_s1.na     = a[W-1];
        n_s1.nb     = b[W-1];
        n_s1.ma     = a[W-1] ? -a : a;
        n_s1.mb     = b[W-1] ? -b : b;
        n_s1.sa     = i_s_axis_tdata[2*W-2:W];
        n_s1.sb     = i_s_axis_tdata[4*W-3:3*W-1];
        if (t_op'(i_s_axis_tuser) == OP_SUB) begin
            n_s1.sum = {a[W-1], a} - {b[W-1], b};
        end else begin
            n_s1.sum = {a[W-1], a} + {b[W-1], b};
        end
    end

    // stage 2: products
    always_comb begin
        n_s2.v   = r_s1.v;
        n_s2.op  = r_s1.op;
        n_s2.neg = r_s1.na ^ r_s1.nb;
        n_s2.dz  = (r_s1.op == OP_DIV) && (r_s1.mb == '0);
        n_s2.sum = r_s1.sum;
        n_s2.ma  = r_s1.ma;
        n_s2.mb  = r_s1.mb;
        n_s2.pv  = TW'(r_s1.ma) * TW'(r_s1.mb);
        n_s2.t1  = TW'(r_s1.mb) * TW'(r_s1.sa);
        n_s2.t2  = TW'(r_s1.ma) * TW'(r_s1.sb);
        n_s2.sa2 = TW'(r_s1.sa) * TW'(r_s1.sa);
        n_s2.sb2 = TW'(r_s1.sb) * TW'(r_s1.sb);
        n_s2.mb2 = TW'(r_s1.mb) * TW'(r_s1.mb);
    end

    // stage 3: partial squares, nominal result for add/sub/mul
    always_comb begin
        logic         sneg;
        logic [W:0]   smag;
        sneg      = r_s2.sum[W];
        smag      = sneg ? -r_s2.sum : r_s2.sum;
        n_s3.v    = r_s2.v;
        n_s3.op   = r_s2.op;
        n_s3.neg  = r_s2.neg;
        n_s3.dz   = r_s2.dz;
        if (r_s2.op == OP_ADD || r_s2.op == OP_SUB) begin
            {n_s3.vovf, n_s3.vres} = f_sat(sneg, NQ'(smag));
        end else begin
            {n_s3.vovf, n_s3.vres} = f_sat(r_s2.neg, NQ'(r_s2.pv >> F));
        end
        n_s3.ma   = r_s2.ma;
        n_s3.mb   = r_s2.mb;
        n_s3.mb2  = r_s2.mb2;
        n_s3.hh1  = TW'(r_s2.t1[TW-1:W]) * TW'(r_s2.t1[TW-1:W]);
        n_s3.hl1  = TW'(r_s2.t1[TW-1:W]) * TW'(r_s2.t1[W-1:0]);
        n_s3.ll1  = TW'(r_s2.t1[W-1:0]) * TW'(r_s2.t1[W-1:0]);
        n_s3.hh2  = TW'(r_s2.t2[TW-1:W]) * TW'(r_s2.t2[TW-1:W]);
        n_s3.hl2  = TW'(r_s2.t2[TW-1:W]) * TW'(r_s2.t2[W-1:0]);
        n_s3.ll2  = TW'(r_s2.t2[W-1:0]) * TW'(r_s2.t2[W-1:0]);
        n_s3.ss   = r_s2.sa2 + r_s2.sb2;
    end

    // stage 4: radicand
    always_comb begin
        logic [XW-1:0] q1;
        logic [XW-1:0] q2;
        q1 = (XW'(r_s3.hh1) << (2*W)) + (XW'(r_s3.hl1) << (W+1)) + XW'(r_s3.ll1);
        q2 = (XW'(r_s3.hh2) << (2*W)) + (XW'(r_s3.hl2) << (W+1)) + XW'(r_s3.ll2);
        n_s4.v    = r_s3.v;
        n_s4.op   = r_s3.op;
        n_s4.neg  = r_s3.neg;
        n_s4.dz   = r_s3.dz;
        n_s4.vres = r_s3.vres;
        n_s4.vovf = r_s3.vovf;
        n_s4.ma   = r_s3.ma;
        n_s4.mb   = r_s3.mb;
        n_s4.mb2  = r_s3.mb2;
        n_s4.x    = (r_s3.op == OP_ADD || r_s3.op == OP_SUB) ? XW'(r_s3.ss) : q1 + q2;
        n_s4.rem  = '0;
        n_s4.root = '0;
    end

    // square root, one bit per stage
    always_comb begin
        for (int i = 0; i < RW; i++) begin
            n_sq[i] = f_sq_step((i == 0) ? r_s4 : r_sq[(i == 0) ? 0 : i-1]);
        end
    end

    // divider entry: non-divide sigma is final here
    always_comb begin
        t_sq           e;
        logic [NQ-1:0] sroot;
        e                 = r_sq[RW-1];
        sroot             = (e.op == OP_MUL) ? (NQ'(e.root) >> F) : NQ'(e.root);
        dv_entry.v        = e.v;
        dv_entry.op       = e.op;
        dv_entry.neg      = e.neg;
        dv_entry.dz       = e.dz;
        dv_entry.vres     = e.vres;
        dv_entry.vovf     = e.vovf;
        {dv_entry.sovf, dv_entry.sres} = f_sig(sroot);
        dv_entry.mb       = e.mb;
        dv_entry.mb2      = e.mb2;
        dv_entry.vq       = NQ'(e.ma) << F;
        dv_entry.vr       = '0;
        dv_entry.sq       = NQ'(e.root) << F;
        dv_entry.sr       = '0;
    end

    // two restoring dividers, one quotient bit per stage
    always_comb begin
        for (int i = 0; i < NQ; i++) begin
            n_dv[i] = f_dv_step((i == 0) ? dv_entry : r_dv[(i == 0) ? 0 : i-1]);
        end
    end

    // output selection
    always_comb begin
        t_dv          d;
        logic         vo;
        logic         so;
        logic [W-1:0] vv;
        logic [W-2:0] ss;
        d = r_dv[NQ-1];
        {vo, vv} = f_sat(d.neg, d.vq);
        {so, ss} = f_sig(d.sq);
        if (d.op != OP_DIV) begin
            n_out_val = d.vres;
            n_out_sig = d.sres;
            n_out_dz  = 1'b0;
            n_out_ovf = d.vovf | d.sovf;
        end else if (d.dz) begin
            n_out_val = '0;
            n_out_sig = '0;
            n_out_dz  = 1'b1;
            n_out_ovf = 1'b0;
        end else begin
            n_out_val = vv;
            n_out_sig = ss;
            n_out_dz  = 1'b0;
            n_out_ovf = vo | so;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1.v  <= 1'b0;
            r_s2.v  <= 1'b0;
            r_s3.v  <= 1'b0;
            r_s4.v  <= 1'b0;
            for (int i = 0; i < RW; i++) begin
                r_sq[i].v <= 1'b0;
            end
            for (int i = 0; i < NQ; i++) begin
                r_dv[i].v <= 1'b0;
            end
            r_out_v <= 1'b0;
        end else if (adv) begin
            r_s1 <= n_s1;
            r_s2 <= n_s2;
            r_s3 <= n_s3;
            r_s4 <= n_s4;
            for (int i = 0; i < RW; i++) begin
                r_sq[i] <= n_sq[i];
            end
            for (int i = 0; i < NQ; i++) begin
                r_dv[i] <= n_dv[i];
            end
            r_out_v   <= r_dv[NQ-1].v;
            r_out_val <= n_out_val;
            r_out_sig <= n_out_sig;
            r_out_dz  <= n_out_dz;
            r_out_ovf <= n_out_ovf;
        end
    end

    assign o_m_axis_tvalid = r_out_v;
    assign o_m_axis_tdata  = ODW'({r_out_sig, r_out_val});
    assign o_m_axis_tuser  = {r_out_ovf, r_out_dz};

    `UPA_ASSERT_IMPL(a_stall_holds_input, i_clk, i_rst_n, o_m_axis_tvalid && !i_m_axis_tready, !o_s_axis_tready, "input accepted while output stalled")
    `UPA_ASSERT_IMPL(a_flags_exclusive, i_clk, i_rst_n, o_m_axis_tvalid && o_m_axis_tuser[0], !o_m_axis_tuser[1], "divide by zero with overflow")
    `UPA_ASSERT_IMPL(a_dz_zero_data, i_clk, i_rst_n, o_m_axis_tvalid && o_m_axis_tuser[0], o_m_axis_tdata == '0, "divide by zero with nonzero data")
    `UPA_ASSERT_NEXT(a_freeze, i_clk, i_rst_n, !o_s_axis_tready, $stable(o_m_axis_tdata), "output changed during stall")

endmodule
`default_nettype wire

// ----- verif/upa_checker.sv -----
// Checker for the uncertainty propagation ALU: watches both stream channels,
// predicts each result from the accepted operands and compares field by field.
// Depends on upa_pkg.
`timescale 1ns / 100ps
module upa_checker (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_in_valid,
    input  wire logic          i_in_ready,
    input  wire logic [127:0]  i_in_data,
    input  wire logic [1:0]    i_in_user,
    input  wire logic          i_out_valid,
    input  wire logic          i_out_ready,
    input  wire logic [63:0]   i_out_data,
    input  wire logic [1:0]    i_out_user,
    output int                 o_errors,
    output int                 o_pending
);
    import upa_pkg::*;

    typedef struct packed {
        logic [31:0] value;
        logic [30:0] sigma;
        logic        dbz;
        logic        ovf;
    } t_res;

    localparam logic [127:0] SMAX = 128'h7FFF_FFFF;

    t_res expected_q[$];

    function automatic logic [127:0] isqrt128(input logic [127:0] x);
        logic [127:0] r;
        logic [127:0] t;
        r = 0;
        for (int i = 63; i >= 0; i--) begin
            t = r | (128'd1 << i);
            if (t * t <= x) r = t;
        end
        return r;
    endfunction

    function automatic t_res predict(input t_op op, input logic [127:0] d);
        logic signed [31:0] a;
        logic signed [31:0] b;
        logic [127:0] ma;
        logic [127:0] mb;
        logic [127:0] sa;
        logic [127:0] sb;
        logic [127:0] mag;
        logic [127:0] sig;
        logic [127:0] t1;
        logic [127:0] t2;
        logic         na;
        logic         nb;
        logic         neg;
        t_res         r;
        a  = d[31:0];
        sa = 128'(d[62:32]);
        b  = d[94:63];
        sb = 128'(d[125:95]);
        na = a[31];
        nb = b[31];
        ma = na ? 128'(-64'(a)) : 128'(a);
        mb = nb ? 128'(-64'(b)) : 128'(b);
        r = '0;
        if (op == OP_ADD || op == OP_SUB) begin
            if (op == OP_SUB) nb = !nb;
            if (na == nb) begin
                mag = ma + mb;
                neg = na;
            end else if (ma >= mb) begin
                mag = ma - mb;
                neg = na;
            end else begin
                mag = mb - ma;
                neg = nb;
            end
            sig = isqrt128(sa * sa + sb * sb);
        end else begin
            if (op == OP_DIV && mb == 0) begin
                r.dbz = 1'b1;
                return r;
            end
            t1 = mb * sa;
            t2 = ma * sb;
            sig = isqrt128(t1 * t1 + t2 * t2);
            neg = na != nb;
            if (op == OP_MUL) begin
                mag = (ma * mb) >> 16;
                sig = sig >> 16;
            end else begin
                mag = (ma << 16) / mb;
                sig = (sig << 16) / (mb * mb);
            end
        end
        if (!neg && mag > SMAX) begin
            mag = SMAX;
            r.ovf = 1'b1;
        end
        if (neg && mag > SMAX + 1) begin
            mag = SMAX + 1;
            r.ovf = 1'b1;
        end
        if (sig > SMAX) begin
            sig = SMAX;
            r.ovf = 1'b1;
        end
        r.value = neg ? -mag[31:0] : mag[31:0];
        r.sigma = sig[30:0];
        return r;
    endfunction

    assign o_pending = expected_q.size();

    always @(posedge i_clk) begin
        t_res exp_r;
        if (!i_rst_n) begin
            o_errors <= 0;
        end else begin
            if (i_in_valid && i_in_ready)
                expected_q.push_back(predict(t_op'(i_in_user), i_in_data));
            if (i_out_valid && i_out_ready) begin
                if (expected_q.size() == 0) begin
                    $display("%0t: unexpected result %h/%b", $time, i_out_data, i_out_user);
                    o_errors <= o_errors + 1;
                end else begin
                    exp_r = expected_q.pop_front();
                    if (exp_r.value !== i_out_data[31:0] || exp_r.sigma !== i_out_data[62:32]
                        || exp_r.dbz !== i_out_user[0] || exp_r.ovf !== i_out_user[1]) begin
                        $display("%0t: mismatch exp val=%h sig=%h dbz=%b ovf=%b",
                                 $time, exp_r.value, exp_r.sigma, exp_r.dbz, exp_r.ovf);
                        $display("%0t:          got val=%h sig=%h dbz=%b ovf=%b",
                                 $time, i_out_data[31:0], i_out_data[62:32],
                                 i_out_user[0], i_out_user[1]);
                        o_errors <= o_errors + 1;
                    end
                end
            end
        end
    end
endmodule

// ----- verif/tb_top.sv -----
// Testbench top for the uncertainty propagation ALU: drives directed and random
// operand streams with random gaps and stalls; verdict from upa_checker.
// Depends on upa_pkg, upa_checker and the block.
`timescale 1ns / 100ps
module tb_top;
    import upa_pkg::*;

    localparam int LATENCY = 149;
    localparam int WATCHDOG = 20000;
    localparam int N_RANDOM = 1830;

    logic         i_clk = 1'b0;
    logic         i_rst_n = 1'b0;
    logic         s_valid = 1'b0;
    logic         s_ready;
    logic [127:0] s_data = '0;
    logic [1:0]   s_user = '0;
    logic         m_valid;
    logic         m_ready = 1'b0;
    logic [63:0]  m_data;
    logic [1:0]   m_user;
    int           errors;
    int           pending;
    int           idle_cycles = 0;
    int           n_sent = 0;
    int           op_count[4] = '{0, 0, 0, 0};
    bit           stim_done = 1'b0;

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    uncertainty_propagation_alu u_top (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_valid),
        .o_s_axis_tready (s_ready),
        .i_s_axis_tdata  (s_data),
        .i_s_axis_tuser  (s_user),
        .o_m_axis_tvalid (m_valid),
        .i_m_axis_tready (m_ready),
        .o_m_axis_tdata  (m_data),
        .o_m_axis_tuser  (m_user)
    );

    upa_checker u_checker (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_valid),
        .i_in_ready  (s_ready),
        .i_in_data   (s_data),
        .i_in_user   (s_user),
        .i_out_valid (m_valid),
        .i_out_ready (m_ready),
        .i_out_data  (m_data),
        .i_out_user  (m_user),
        .o_errors    (errors),
        .o_pending   (pending)
    );

    function automatic int gap_len();
        int p;
        p = $urandom_range(99);
        if (p < 50) return 0;
        if (p < 92) return $urandom_range(3);
        return $urandom_range(40);
    endfunction

    function automatic logic [31:0] rand_value();
        case ($urandom_range(5))
            0: return $urandom;
            1: return 32'($signed($urandom_range(1 << 20)) - (1 << 19));
            2: return $urandom_range(1) ? 32'h7FFF_FFFF : 32'h8000_0000;
            3: return 32'($signed($urandom_range(8)) - 4);
            default: return 32'($signed($urandom_range(1 << 24)) - (1 << 23));
        endcase
    endfunction

    function automatic logic [30:0] rand_sigma();
        case ($urandom_range(3))
            0: return 31'($urandom);
            1: return 31'($urandom_range(1 << 18));
            2: return $urandom_range(1) ? 31'h7FFF_FFFF : 31'd0;
            default: return 31'($urandom_range(1 << 12));
        endcase
    endfunction

    task automatic send(input t_op op, input logic [31:0] a, input logic [30:0] sa,
                        input logic [31:0] b, input logic [30:0] sb);
        int g;
        g = gap_len();
        repeat (g) begin
            s_valid <= 1'b0;
            @(negedge i_clk);
        end
        s_valid <= 1'b1;
        s_user  <= op;
        s_data  <= {2'b00, sb, b, sa, a};
        @(posedge i_clk);
        while (!s_ready) @(posedge i_clk);
        @(negedge i_clk);
        n_sent++;
        op_count[op]++;
    endtask

    task automatic wait_drained();
        s_valid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
    endtask

    initial begin
        t_op op;
        repeat (5) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);
        for (int k = 0; k < 4; k++) begin
            op = t_op'(k);
            send(op, 32'h7FFF_FFFF, 31'h7FFF_FFFF, 32'h7FFF_FFFF, 31'h7FFF_FFFF);
            send(op, 32'h8000_0000, 31'd0, 32'h8000_0000, 31'h7FFF_FFFF);
            send(op, 32'h0001_0000, 31'h0000_8000, 32'hFFFF_0000, 31'h0001_0000);
            send(op, 32'h0000_0000, 31'd0, 32'h0000_0001, 31'd1);
            send(op, 32'h8000_0000, 31'd3, 32'h0000_0001, 31'd0);
        end
        send(OP_DIV, 32'h1234_5678, 31'h0111_0000, 32'd0, 31'h0000_1000);
        send(OP_DIV, 32'h8000_0000, 31'h7FFF_FFFF, 32'd0, 31'd0);
        send(OP_SUB, 32'h8000_0000, 31'd0, 32'h0000_0001, 31'd0);
        wait_drained();
        for (int n = 0; n < N_RANDOM; n++) begin
            op = t_op'($urandom_range(3));
            send(op, rand_value(), rand_sigma(),
                 (op == OP_DIV && $urandom_range(15) == 0) ? 32'd0 : rand_value(),
                 rand_sigma());
            if (n == N_RANDOM / 2) wait_drained();
        end
        s_valid <= 1'b0;
        stim_done = 1'b1;
    end

    initial begin
        int g;
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            if ($urandom_range(3) == 0) begin
                g = gap_len();
                m_ready <= 1'b0;
                repeat (g) @(negedge i_clk);
            end
            m_ready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    initial begin
        wait (stim_done);
        while (pending != 0) @(negedge i_clk);
        repeat (LATENCY + 20) @(negedge i_clk);
        $display("Sent %0d items: add %0d, sub %0d, mul %0d, div %0d; with stalls, gaps",
                 n_sent, op_count[0], op_count[1], op_count[2], op_count[3]);
        $display("and a full drain mid-run; %0d errors", errors);
        if (errors == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end
endmodule

// ----- uncertainty_propagation_alu.f -----
+incdir+rtl/core
rtl/core/upa_pkg.sv
rtl/core/uncertainty_propagation_alu.sv
verif/upa_checker.sv
verif/tb_top.sv
